// ----- sv/asfp_pkg.sv -----
// Shared types and constants of the converter sample frame packer.
package asfp_pkg;

   localparam logic [15:0] HDR_HE = 16'h6568;
   localparam logic [15:0] HDR_AD = 16'h6461;
   localparam logic [15:0] HDR_TA = 16'h6174;
   localparam logic [15:0] HDR_IL = 16'h6C69;

   localparam logic [15:0] FRAME_LENGTH_RESET = 16'd500;
   localparam logic [15:0] RATE_FIELD_RESET   = 16'd2000;
   localparam logic [9:0]  MID_LEVEL_RESET    = 10'd512;

   typedef enum logic [1:0] {
      REG_FRAME_LENGTH = 2'd0,
      REG_RATE_FIELD   = 2'd1,
      REG_MID_LEVEL    = 2'd2,
      REG_UNUSED       = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      SLOT_HE      = 4'd0,
      SLOT_AD      = 4'd1,
      SLOT_ID_LO   = 4'd2,
      SLOT_ID_HI   = 4'd3,
      SLOT_LENGTH  = 4'd4,
      SLOT_RATE    = 4'd5,
      SLOT_TA      = 4'd6,
      SLOT_IL      = 4'd7,
      SLOT_SAMPLE  = 4'd8
   } slot_type;

   typedef struct packed {
      logic        start;
      logic        frame_end;
      logic [15:0] sample;
      logic [31:0] packet_id;
      logic [15:0] frame_length;
      logic [15:0] rate_field;
   } cmd_type;

endpackage

// ----- sv/adc_sample_frame_packer_top.sv -----
// Top level of the converter sample frame packer.
//
// The req_ channel takes one converter word per transaction; only bits 9..0 are used and the
// configured mid level is subtracted to give a signed 16-bit sample. The rsp_ channel gives
// 16-bit packet words with frame_start on the first header word and frame_end on the last
// sample of a frame. A frame opens with eight header words sent just ahead of its first sample.
// The csr_ channel writes frame_length (0), rate_field (1) and mid_level (2); it is always ready
// and should be written only while the block is idle.
// A transaction enters a two-entry command queue in the cycle it is accepted; the back part
// registers its words in its output word register. A sample inside a frame gives one word,
// a sample that opens a frame gives nine, so the output word rate is one per cycle while
// the receiver is ready, and the input rate is set by the header expansion in the back part.
// Reset clears the counters, sets packet id to zero (the first frame carries id 1) and loads
// the register defaults. When the receiver stalls the output word holds, the queue fills and
// req_ready falls.
module adc_sample_frame_packer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_raw_sample,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_word,
   output logic        rsp_frame_end,
   output logic        rsp_frame_start
);

   logic              push;
   logic              pop;
   logic              queue_full;
   logic              queue_empty;
   asfp_pkg::cmd_type push_data;
   asfp_pkg::cmd_type head;

   asfp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_sample (req_raw_sample),
      .queue_full     (queue_full),
      .push           (push),
      .push_data      (push_data)
   );

   asfp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head      (head)
   );

   asfp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .head            (head),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_word        (rsp_word),
      .rsp_frame_end   (rsp_frame_end),
      .rsp_frame_start (rsp_frame_start)
   );

endmodule

// ----- sv/asfp_fifo.sv -----
// Two-entry command queue between the front and back parts of the packer.
module asfp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  asfp_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output asfp_pkg::cmd_type head
);

   asfp_pkg::cmd_type mem_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign head    = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/asfp_front.sv -----
// Front part: configuration registers, sample conversion and frame classification.
module asfp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [15:0]       req_raw_sample,
   input  logic              queue_full,
   output logic              push,
   output asfp_pkg::cmd_type push_data
);

   logic [15:0] frame_length_ff, frame_length_in;
   logic [15:0] rate_field_ff, rate_field_in;
   logic [9:0]  mid_level_ff, mid_level_in;
   logic [15:0] sample_count_ff, sample_count_in;
   logic [31:0] packet_id_ff, packet_id_in;
   logic        csr_write;
   logic        start;
   logic [16:0] next_count;
   logic        frame_end;
   logic [31:0] id_next;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign start      = (sample_count_ff == 16'd0);
   assign id_next    = packet_id_ff + 32'd1;
   assign next_count = {1'b0, sample_count_ff} + 17'd1;
   assign frame_end  = (next_count >= {1'b0, frame_length_ff});

   always_comb begin
      push_data.start        = start;
      push_data.frame_end    = frame_end;
      push_data.sample       = {6'd0, req_raw_sample[9:0]} - {6'd0, mid_level_ff};
      push_data.packet_id    = id_next;
      push_data.frame_length = frame_length_ff;
      push_data.rate_field   = rate_field_ff;
   end

   always_comb begin
      frame_length_in = frame_length_ff;
      rate_field_in   = rate_field_ff;
      mid_level_in    = mid_level_ff;
      if (csr_write) begin
         case (asfp_pkg::reg_index_type'(csr_index))
            asfp_pkg::REG_FRAME_LENGTH: frame_length_in = csr_data;
            asfp_pkg::REG_RATE_FIELD:   rate_field_in   = csr_data;
            asfp_pkg::REG_MID_LEVEL:    mid_level_in    = csr_data[9:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      sample_count_in = sample_count_ff;
      packet_id_in    = packet_id_ff;
      if (push) begin
         sample_count_in = frame_end ? 16'd0 : next_count[15:0];
         if (start) begin
            packet_id_in = id_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff <= asfp_pkg::FRAME_LENGTH_RESET;
         rate_field_ff   <= asfp_pkg::RATE_FIELD_RESET;
         mid_level_ff    <= asfp_pkg::MID_LEVEL_RESET;
         sample_count_ff <= 16'd0;
         packet_id_ff    <= 32'd0;
      end else begin
         frame_length_ff <= frame_length_in;
         rate_field_ff   <= rate_field_in;
         mid_level_ff    <= mid_level_in;
         sample_count_ff <= sample_count_in;
         packet_id_ff    <= packet_id_in;
      end
   end

endmodule

// ----- sv/asfp_back.sv -----
// Back part: expands queued commands into header and sample words on the result channel.
module asfp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  asfp_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_word,
   output logic              rsp_frame_end,
   output logic              rsp_frame_start
);

   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         word_ff, word_in;
   logic                frame_end_ff, frame_end_in;
   logic                frame_start_ff, frame_start_in;
   logic [3:0]          slot_ff, slot_in;
   logic                load;
   asfp_pkg::slot_type  sel;
   logic [15:0]         sel_word;

   assign load = !rsp_valid_ff || rsp_ready;
   assign sel  = head.start ? asfp_pkg::slot_type'(slot_ff) : asfp_pkg::SLOT_SAMPLE;
   assign pop  = load && !queue_empty && (sel == asfp_pkg::SLOT_SAMPLE);

   always_comb begin
      case (sel)
         asfp_pkg::SLOT_HE:     sel_word = asfp_pkg::HDR_HE;
         asfp_pkg::SLOT_AD:     sel_word = asfp_pkg::HDR_AD;
         asfp_pkg::SLOT_ID_LO:  sel_word = head.packet_id[15:0];
         asfp_pkg::SLOT_ID_HI:  sel_word = head.packet_id[31:16];
         asfp_pkg::SLOT_LENGTH: sel_word = head.frame_length;
         asfp_pkg::SLOT_RATE:   sel_word = head.rate_field;
         asfp_pkg::SLOT_TA:     sel_word = asfp_pkg::HDR_TA;
         asfp_pkg::SLOT_IL:     sel_word = asfp_pkg::HDR_IL;
         default:               sel_word = head.sample;
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      word_in        = word_ff;
      frame_end_in   = frame_end_ff;
      frame_start_in = frame_start_ff;
      slot_in        = slot_ff;
      if (load) begin
         rsp_valid_in = !queue_empty;
         if (!queue_empty) begin
            word_in        = sel_word;
            frame_start_in = head.start && (sel == asfp_pkg::SLOT_HE);
            frame_end_in   = head.frame_end && (sel == asfp_pkg::SLOT_SAMPLE);
            slot_in        = (sel == asfp_pkg::SLOT_SAMPLE) ? 4'd0 : slot_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         slot_ff      <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff        <= word_in;
      frame_end_ff   <= frame_end_in;
      frame_start_ff <= frame_start_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_word        = word_ff;
   assign rsp_frame_end   = frame_end_ff;
   assign rsp_frame_start = frame_start_ff;

`ifndef SYNTHESIS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= 4'd8)
      else $error("Word slot counter out of range.");

   a_start_is_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && frame_start_ff |-> word_ff == asfp_pkg::HDR_HE && !frame_end_ff)
      else $error("Frame start flag is not on a header opening word.");

   a_header_runs: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 4'd0 |-> !queue_empty && head.start)
      else $error("Header expansion lost its command.");
`endif

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the converter sample frame packer, with a frame predictor.
`timescale 1ns / 100ps

module testbench;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SEGMENTS = 6;
   localparam int SEGMENT_SAMPLES = 84;

   typedef struct packed {
      logic [15:0] word;
      logic        frame_end;
      logic        frame_start;
   } packet_word_type;

   class frame_scoreboard;
      logic [15:0] frame_length;
      logic [15:0] rate_field;
      logic [9:0]  mid_level;
      logic [15:0] samples_in_frame;
      logic [31:0] packet_id;
      packet_word_type expected_words[$];
      int errors;
      int words_checked;
      int frames_opened;
      int samples_noted;

      function new();
         frame_length = asfp_pkg::FRAME_LENGTH_RESET;
         rate_field = asfp_pkg::RATE_FIELD_RESET;
         mid_level = asfp_pkg::MID_LEVEL_RESET;
         samples_in_frame = '0;
         packet_id = '0;
         errors = 0;
         words_checked = 0;
         frames_opened = 0;
         samples_noted = 0;
      endfunction

      function void write_reg(asfp_pkg::reg_index_type idx, logic [15:0] data);
         case (idx)
            asfp_pkg::REG_FRAME_LENGTH: frame_length = data;
            asfp_pkg::REG_RATE_FIELD:   rate_field = data;
            asfp_pkg::REG_MID_LEVEL:    mid_level = data[9:0];
            default: ;
         endcase
      endfunction

      function void push_word(logic [15:0] word, logic fend, logic fstart);
         packet_word_type w;
         w.word = word;
         w.frame_end = fend;
         w.frame_start = fstart;
         expected_words.push_back(w);
      endfunction

      function void note_sample(logic [15:0] raw);
         logic [15:0] level;
         logic [16:0] next_count;
         logic        closes;
         level = {6'b0, raw[9:0]} - {6'b0, mid_level};
         samples_noted++;
         if (samples_in_frame == 16'd0) begin
            packet_id = packet_id + 32'd1;
            frames_opened++;
            push_word(asfp_pkg::HDR_HE, 1'b0, 1'b1);
            push_word(asfp_pkg::HDR_AD, 1'b0, 1'b0);
            push_word(packet_id[15:0], 1'b0, 1'b0);
            push_word(packet_id[31:16], 1'b0, 1'b0);
            push_word(frame_length, 1'b0, 1'b0);
            push_word(rate_field, 1'b0, 1'b0);
            push_word(asfp_pkg::HDR_TA, 1'b0, 1'b0);
            push_word(asfp_pkg::HDR_IL, 1'b0, 1'b0);
         end
         next_count = {1'b0, samples_in_frame} + 17'd1;
         closes = (next_count >= {1'b0, frame_length});
         push_word(level, closes, 1'b0);
         samples_in_frame = closes ? 16'd0 : next_count[15:0];
      endfunction

      function void flag(string what);
         errors++;
         if (errors <= 10) $display("%0t: %s", $time, what);
      endfunction

      function void check_word(packet_word_type got);
         packet_word_type want;
         words_checked++;
         if (expected_words.size() == 0) begin
            flag($sformatf("unexpected packet word %h end %b start %b",
                           got.word, got.frame_end, got.frame_start));
            return;
         end
         want = expected_words.pop_front();
         if (got.word !== want.word || got.frame_end !== want.frame_end ||
             got.frame_start !== want.frame_start)
            flag($sformatf({"packet word mismatch: expected %h end %b start %b, ",
                            "got %h end %b start %b"},
                           want.word, want.frame_end, want.frame_start,
                           got.word, got.frame_end, got.frame_start));
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_raw_sample;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_word;
   logic        rsp_frame_end;
   logic        rsp_frame_start;

   frame_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   int reg_writes;
   int idle_cycles;

   adc_sample_frame_packer_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_raw_sample (req_raw_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .rsp_frame_end  (rsp_frame_end),
      .rsp_frame_start(rsp_frame_start)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word({rsp_word, rsp_frame_end, rsp_frame_start});
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d packet words outstanding.", sb.pending());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] raw);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_sample <= raw;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(raw);
   endtask

   task automatic feed(input logic [15:0] raws[$]);
      foreach (raws[i]) send_sample(raws[i]);
      req_valid <= 1'b0;
   endtask

   task automatic settle();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] length, input logic [15:0] rate,
                               input logic [15:0] mid_word, input bit poke_unused);
      asfp_pkg::reg_index_type idx[4];
      logic [15:0]             val[4];
      int                      n;
      idx = '{asfp_pkg::REG_FRAME_LENGTH, asfp_pkg::REG_RATE_FIELD,
              asfp_pkg::REG_MID_LEVEL, asfp_pkg::REG_UNUSED};
      val = '{length, rate, mid_word, 16'($urandom)};
      n = poke_unused ? 4 : 3;
      settle();
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         sb.write_reg(idx[i], val[i]);
         reg_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [15:0] pick_raw();
      logic [15:0] r;
      r = 16'($urandom);
      case ($urandom_range(7))
         0: r[9:0] = 10'h000;
         1: r[9:0] = 10'h3FF;
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(60, 20));
         default: return 16'($urandom_range(12, 1));
      endcase
   endfunction

   function automatic logic [15:0] pick_mid_word();
      logic [15:0] m;
      m = 16'($urandom);
      case ($urandom_range(5))
         0: m[9:0] = 10'd0;
         1: m[9:0] = 10'd1023;
         default: ;
      endcase
      return m;
   endfunction

   initial begin
      logic [15:0] batch[$];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_raw_sample <= '0;
      csr_valid <= 1'b0;
      csr_index <= asfp_pkg::REG_FRAME_LENGTH;
      csr_data <= '0;
      send_idle_pct = 25;
      recv_idle_pct = 58;
      reg_writes = 0;
      idle_cycles = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Register defaults first, then zero and unit frame lengths and the register extremes.
      feed('{16'h0000, 16'hFFFF, 16'h03FF, 16'hFC00, 16'h0200});
      program_regs(16'd0, 16'hFFFF, {6'h3F, 10'd0}, 1'b1);
      feed('{16'h03FF, 16'h0000, 16'hAAAA});
      program_regs(16'd1, 16'd0, {6'h00, 10'd1023}, 1'b0);
      feed('{16'h0000, 16'h03FF, 16'h5555});
      // The frame length shrinks from 4 to 2 while a frame is open, so that frame closes on its next sample.
      program_regs(16'd4, 16'd1234, {6'h15, 10'd512}, 1'b0);
      feed('{16'h0123, 16'h8200, 16'h7FFF});
      program_regs(16'd2, 16'd1234, {6'h15, 10'd512}, 1'b0);
      feed('{16'h01FF, 16'h0201});
      program_regs(16'hFFFF, 16'hFFFF, {6'h2A, 10'h155}, 1'b1);
      feed('{16'h0155, 16'hFEAA, 16'h3C3C});

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         program_regs(pick_length(), 16'($urandom), pick_mid_word(), $urandom_range(3) == 0);
         case (seg / 2)
            0: begin
               send_idle_pct = 25;
               recv_idle_pct = 58;
            end
            1: begin
               send_idle_pct = 58;
               recv_idle_pct = 25;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         batch.delete();
         for (int i = 0; i < SEGMENT_SAMPLES; i++) batch.push_back(pick_raw());
         feed(batch);
      end

      settle();
      repeat (20) @(posedge clock);
      $display("Run covered %0d sample transactions in %0d frames, %0d packet words, %0d %s.",
               sb.samples_noted, sb.frames_opened, sb.words_checked, reg_writes,
               "register writes");
      $display("Frame lengths from zero to 65535, mid levels at both ends, %s; %0d errors.",
               "three stall patterns", sb.errors);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/asfp_pkg.sv
sv/asfp_fifo.sv
sv/asfp_front.sv
sv/asfp_back.sv
sv/adc_sample_frame_packer_top.sv
dv/testbench.sv
